@@ hdl/cua_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cua_pkg
// Shared constants and types of the contiguous unit allocator.
// ---------------------------------------------------------------------------
package cua_pkg;

   localparam int UNITS_DEFAULT = 512;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   localparam logic [1:0] ST_ALLOC  = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_STALL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_SCAN_END,
      S_MIN,
      S_FREE,
      S_TICK_END,
      S_CLAIM,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

@@ hdl/contiguous_unit_allocator_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// contiguous_unit_allocator_core
// Contiguous run allocator with first/best/worst/next fit and oldest-job ticks.
// ---------------------------------------------------------------------------
// channel | dir | handshake         | payload
// req     | in  | req_valid/ready   | job_id, unit_count, hold_ticks
// rsp     | out | rsp_valid/ready   | status, start_unit, ticks_waited
// csr     | in  | csr_valid/ready   | fit_mode
// One request at a time. Each fit attempt walks the table one unit a cycle
// (in two segments when next fit wraps to its second segment); each
// failed attempt adds a min pass and an update pass over the table. A
// claim writes unit_count units of the table. Walks and passes share the
// single table read port.
// Reset clears control state only; the table is cleared by a pass over all
// UNITS units after reset, during which req_ready is low.
// A response waits in rsp registers until taken; req_ready stays low meanwhile.
module contiguous_unit_allocator_core #(
   parameter int UNITS = cua_pkg::UNITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_job_id,
   input  wire logic [9:0]  req_unit_count,
   input  wire logic [15:0] req_hold_ticks,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_start_unit,
   output logic [15:0]      rsp_ticks_waited,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_fit_mode
);
   import cua_pkg::*;

   localparam int AW = $clog2(UNITS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] UNITS_C = CW'(UNITS);

   logic [31:0] tab_mem [UNITS];   // {owner, remaining}

   state_type state_ff, state_in;
   state_type state_sel, tick_sel;
   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   id_ff, id_in, hold_ff, hold_in;
   logic [CW-1:0] need_ff, need_in;
   logic [15:0]   oldest_ff, oldest_in;
   logic [AW-1:0] nf_ff, nf_in;
   logic [16:0]   waited_ff, waited_in;
   logic [CW-1:0] cnt_ff, cnt_in;       // scan address / claim counter
   logic          clr_ff, clr_in;
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          pass_ff, pass_in;     // next fit second segment
   logic [CW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] run_st_ff, run_st_in;
   logic          pick_ok_ff, pick_ok_in;
   logic [AW-1:0] pick_ff, pick_in;
   logic [CW-1:0] pick_len_ff, pick_len_in;
   logic [15:0]   min_ff, min_in;
   logic          any_ff, any_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [8:0]    ru_ff, ru_in;
   logic [15:0]   rt_ff, rt_in;
   logic          rd_v_ff, rd_v_in;     // read data valid for address rd_a_ff
   logic [AW-1:0] rd_a_ff;
   logic [31:0]   rd_q_ff;

   logic          we;
   logic [AW-1:0] wa, ra;
   logic [31:0]   wd;
   logic          run_close, run_fits, take;
   logic [CW-1:0] seg_hi, close_len;
   logic [AW-1:0] close_st;
   logic          free_u;
   logic [CW-1:0] nf_sum;

   always_ff @(posedge clock) begin
      if (we) tab_mem[wa] <= wd;
      rd_q_ff <= tab_mem[ra];
      rd_a_ff <= ra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; mode_ff <= FIT_FIRST; oldest_ff <= 16'd1; nf_ff <= '0;
         clr_ff <= 1'b1; clr_cnt_ff <= '0; rv_ff <= 1'b0; rd_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; mode_ff <= mode_in; oldest_ff <= oldest_in; nf_ff <= nf_in;
         clr_ff <= clr_in; clr_cnt_ff <= clr_cnt_in; rv_ff <= rv_in; rd_v_ff <= rd_v_in;
      end
      id_ff <= id_in; hold_ff <= hold_in; need_ff <= need_in; waited_ff <= waited_in;
      cnt_ff <= cnt_in; pass_ff <= pass_in; run_len_ff <= run_len_in;
      run_st_ff <= run_st_in; pick_ok_ff <= pick_ok_in; pick_ff <= pick_in;
      pick_len_ff <= pick_len_in; min_ff <= min_in; any_ff <= any_in;
      rs_ff <= rs_in; ru_ff <= ru_in; rt_ff <= rt_in;
   end

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !clr_ff && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_start_unit = ru_ff;
   assign rsp_ticks_waited = rt_ff;

   // next fit pointer: end of the claimed run, wrapped by one compare
   assign nf_sum = {1'b0, pick_ff} + need_ff;

   // scan segment upper bound
   always_comb begin
      if (mode_ff == FIT_NEXT && !pass_ff) seg_hi = UNITS_C;
      else if (mode_ff == FIT_NEXT) seg_hi = {1'b0, nf_ff};
      else seg_hi = UNITS_C;
   end

   assign free_u = (rd_q_ff[31:16] == 16'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_valid && req_ready) state_in = S_CHECK;
         S_CHECK:    state_in = S_SCAN;
         S_SCAN:     if (run_close && (cnt_ff >= seg_hi)) state_in = S_SCAN_END;
                     else if (take) state_in = S_SCAN_END;
         S_SCAN_END: state_in = S_SCAN;
         S_MIN:      if (cnt_ff == UNITS_C) state_in = S_FREE;
         S_FREE:     if (cnt_ff == UNITS_C) state_in = S_TICK_END;
         S_TICK_END: state_in = S_SCAN;
         S_CLAIM:    if (cnt_ff == need_ff) state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
      // outcomes decided in the datapath block override
      if (state_ff == S_CHECK && rv_in) state_in = S_IDLE;
      if (state_ff == S_SCAN_END) state_in = state_sel;
      if (state_ff == S_TICK_END) state_in = tick_sel;
   end

   // scan compare: reading in order, rd_q_ff holds unit cnt_ff-1
   always_comb begin
      run_close = 1'b0;
      close_len = run_len_ff;
      close_st  = run_st_ff;
      if (state_ff == S_SCAN && rd_v_ff) begin
         if (!free_u) run_close = 1'b1;
         else if (cnt_ff >= seg_hi) begin
            run_close = 1'b1;
            close_len = run_len_ff + 1'b1;
            if (run_len_ff == '0) close_st = rd_a_ff;
         end
      end else if (state_ff == S_SCAN && cnt_ff >= seg_hi && !rd_v_ff) begin
         run_close = 1'b1;
      end
      run_fits = run_close && (close_len >= need_ff) && (close_len != '0);
      take = run_fits && (mode_ff == FIT_FIRST || mode_ff == FIT_NEXT);
   end

   // datapath and outputs
   always_comb begin
      mode_in = mode_ff; id_in = id_ff; hold_in = hold_ff; need_in = need_ff;
      oldest_in = oldest_ff; nf_in = nf_ff; waited_in = waited_ff; cnt_in = cnt_ff;
      clr_in = clr_ff; clr_cnt_in = clr_cnt_ff; pass_in = pass_ff;
      run_len_in = run_len_ff; run_st_in = run_st_ff; pick_ok_in = pick_ok_ff;
      pick_in = pick_ff; pick_len_in = pick_len_ff; min_in = min_ff; any_in = any_ff;
      rv_in = rv_ff; rs_in = rs_ff; ru_in = ru_ff; rt_in = rt_ff;
      rd_v_in = 1'b0;
      we = 1'b0; wa = '0; wd = '0; ra = '0;
      state_sel = S_SCAN; tick_sel = S_SCAN;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (csr_valid && csr_ready) mode_in = csr_fit_mode;
      if (clr_ff) begin
         we = 1'b1; wa = clr_cnt_ff[AW-1:0];
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == UNITS_C - 1'b1) clr_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               id_in = req_job_id; hold_in = req_hold_ticks;
               need_in = (req_unit_count > 10'(UNITS)) ? '0 : CW'(req_unit_count);
               waited_in = '0;
            end
         end
         S_CHECK: begin
            if (need_ff == '0 || hold_ff == 16'd0 || id_ff == 16'd0) begin
               rv_in = 1'b1; rs_in = ST_REJECT; ru_in = '0; rt_in = '0;
            end
            cnt_in = (mode_ff == FIT_NEXT) ? {1'b0, nf_ff} : '0;
            pass_in = 1'b0; run_len_in = '0; pick_ok_in = 1'b0;
         end
         S_SCAN: begin
            if (cnt_ff < seg_hi) begin
               ra = cnt_ff[AW-1:0]; rd_v_in = 1'b1; cnt_in = cnt_ff + 1'b1;
            end
            if (rd_v_ff) begin
               if (free_u) begin
                  if (run_len_ff == '0) run_st_in = rd_a_ff;
                  run_len_in = run_len_ff + 1'b1;
               end else run_len_in = '0;
            end
            if (run_fits) begin
               if (take) begin
                  pick_ok_in = 1'b1; pick_in = close_st;
               end else if (mode_ff == FIT_BEST) begin
                  if (!pick_ok_ff || close_len < pick_len_ff) begin
                     pick_ok_in = 1'b1; pick_in = close_st; pick_len_in = close_len;
                  end
               end else if (!pick_ok_ff || close_len >= pick_len_ff) begin
                  pick_ok_in = 1'b1; pick_in = close_st; pick_len_in = close_len;
               end
            end
            if (take || (run_close && cnt_ff >= seg_hi)) rd_v_in = 1'b0;
         end
         S_SCAN_END: begin
            run_len_in = '0;
            if (pick_ok_ff) begin
               state_sel = S_CLAIM; cnt_in = '0;
               if (mode_ff == FIT_NEXT)
                  nf_in = (nf_sum >= UNITS_C) ? AW'(nf_sum - UNITS_C) : nf_sum[AW-1:0];
            end else if (mode_ff == FIT_NEXT && !pass_ff && nf_ff != '0) begin
               state_sel = S_SCAN; pass_in = 1'b1; cnt_in = '0;
            end else begin
               state_sel = S_MIN; cnt_in = '0; min_in = '0; any_in = 1'b0;
            end
         end
         S_MIN: begin
            if (cnt_ff < UNITS_C) begin
               ra = cnt_ff[AW-1:0]; rd_v_in = 1'b1; cnt_in = cnt_ff + 1'b1;
            end else cnt_in = '0;
            if (rd_v_ff && rd_q_ff[31:16] == oldest_ff) begin
               any_in = 1'b1;
               if (rd_q_ff[15:0] != 16'd0 && (min_ff == 16'd0 || rd_q_ff[15:0] < min_ff))
                  min_in = rd_q_ff[15:0];
            end
         end
         S_FREE: begin
            if (cnt_ff < UNITS_C) begin
               ra = cnt_ff[AW-1:0]; rd_v_in = 1'b1; cnt_in = cnt_ff + 1'b1;
            end
            if (rd_v_ff && rd_q_ff[31:16] == oldest_ff) begin
               we = 1'b1; wa = rd_a_ff;
               if (min_ff == 16'd0 || rd_q_ff[15:0] == min_ff) wd = {16'd0, 16'd0};
               else wd = {rd_q_ff[31:16], rd_q_ff[15:0] - min_ff};
            end
         end
         S_TICK_END: begin
            if (!any_ff) begin
               tick_sel = S_IDLE;
               rv_in = 1'b1; rs_in = ST_STALL; ru_in = '0; rt_in = waited_ff[15:0];
            end else begin
               oldest_in = oldest_ff + 16'd1;
               waited_in = waited_ff + ((min_ff == 16'd0) ? 17'd1 : {1'b0, min_ff});
               if (waited_in > 17'h0FFFF) waited_in = 17'h0FFFF;
               cnt_in = (mode_ff == FIT_NEXT) ? {1'b0, nf_ff} : '0;
               pass_in = 1'b0; pick_ok_in = 1'b0; run_len_in = '0;
            end
         end
         S_CLAIM: begin
            if (cnt_ff < need_ff) begin
               we = 1'b1; wa = AW'({1'b0, pick_ff} + cnt_ff); wd = {id_ff, hold_ff};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            rv_in = 1'b1; rs_in = ST_ALLOC; ru_in = 9'({1'b0, pick_ff});
            rt_in = waited_ff[15:0];
         end
         default: ;
      endcase
   end

`ifndef SYNTH
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(rs_ff))
      else $error("response dropped while stalled");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready)
      else $error("request accepted with response pending");
   a_claim_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLAIM && cnt_ff < need_ff |-> ({1'b0, pick_ff} + cnt_ff) < UNITS_C)
      else $error("claim past end of table");
`endif
endmodule
`default_nettype wire
